FILE: sv/phdt_pkg.sv
package phdt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Request kinds
  typedef enum logic [1:0] {
    KIND_REGISTER   = 2'd0,
    KIND_UNREGISTER = 2'd1,
    KIND_DISPATCH   = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // One table slot
  typedef struct packed {
    logic [15:0] pin;
    logic [7:0]  hid;
  } entry_t;

  // Compare unit result
  typedef struct packed {
    logic pin_hit;
    logic pair_hit;
  } cmp_t;

endpackage

FILE: sv/phdt_table_mem.sv
module phdt_table_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [phdt_pkg::IDX_W-1:0] waddr,
  input  phdt_pkg::entry_t          wdata,
  input  logic [phdt_pkg::IDX_W-1:0] raddr,
  output phdt_pkg::entry_t          rdata
);
  import phdt_pkg::*;

  entry_t mem [TABLE_DEPTH];

  // Write one slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/phdt_cmp.sv
module phdt_cmp (
  input  phdt_pkg::entry_t entry,
  input  logic [15:0]      key_pin,
  input  logic [7:0]       key_hid,
  output phdt_pkg::cmp_t   hit
);
  import phdt_pkg::*;

  // Compare one slot against the request key
  always_comb begin
    hit.pin_hit  = (entry.pin == key_pin);
    hit.pair_hit = (entry.pin == key_pin) && (entry.hid == key_hid);
  end

endmodule

FILE: sv/pin_handler_dispatch_table.sv
// Sequencing: register, unused kind, or lookup on an empty table go from start straight to
//   the result. Dispatch/unregister scan the slots one by one, and a successful unregister
//   then moves each later slot down one place.
// Throughput: one request at a time; the next is taken the cycle after the result leaves.
//   The single slot comparator and the one read port of the table memory set the pace.
// Reset (rst, synchronous): table empty, sequencer idle; slot contents are not cleared.
module pin_handler_dispatch_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] pin_mask,
  input  logic [7:0]  handler_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [7:0]  matched_handler,
  output logic [3:0]  entry_count
);
  import phdt_pkg::*;

  localparam logic [CNT_W:0] DEPTH_X = (CNT_W + 1)'(TABLE_DEPTH);

  state_t          state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]      req_kind;
  logic [15:0]     req_pin;
  logic [7:0]      req_hid;
  logic            res_status, res_status_next;
  logic [7:0]      res_hid, res_hid_next;

  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;
  cmp_t            hit;

  logic [CNT_W:0]  count_x, idx_x, idx_p1, idx_p2;
  logic [CNT_W+3:0] count_wide;
  logic            full, empty, more_scan, more_shift, is_hit;

  phdt_table_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  phdt_cmp u_cmp (
    .entry   (mem_rdata),
    .key_pin (req_pin),
    .key_hid (req_hid),
    .hit     (hit)
  );

  // Index and count arithmetic
  assign count_x    = {1'b0, count};
  assign idx_x      = {{(CNT_W + 1 - IDX_W){1'b0}}, idx};
  assign idx_p1     = idx_x + (CNT_W + 1)'(1);
  assign idx_p2     = idx_x + (CNT_W + 1)'(2);
  assign full       = (count_x >= DEPTH_X);
  assign empty      = (count == '0);
  assign more_scan  = (idx_p1 < count_x);
  assign more_shift = (idx_p2 < count_x);
  assign is_hit     = (req_kind == KIND_DISPATCH) ? hit.pin_hit : hit.pair_hit;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        case (req_kind)
          KIND_UNREGISTER, KIND_DISPATCH: state_next = empty ? S_DONE : S_SCAN;
          default:                        state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (is_hit) begin
          if (req_kind == KIND_UNREGISTER && more_scan) state_next = S_SHIFT;
          else                                          state_next = S_DONE;
        end else if (!more_scan) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!more_shift) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls and result values
  always_comb begin
    idx_next        = idx;
    count_next      = count;
    res_status_next = res_status;
    res_hid_next    = res_hid;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = mem_rdata;
    mem_raddr       = '0;
    case (state)
      S_START: begin
        res_status_next = 1'b1;
        res_hid_next    = '0;
        idx_next        = '0;
        if (req_kind == KIND_REGISTER && !full) begin
          // append at the tail
          mem_we          = 1'b1;
          mem_waddr       = count_x[IDX_W-1:0];
          mem_wdata.pin   = req_pin;
          mem_wdata.hid   = req_hid;
          count_next      = count + CNT_W'(1);
          res_status_next = 1'b0;
        end
      end
      S_SCAN: begin
        mem_raddr = idx_p1[IDX_W-1:0];
        if (is_hit) begin
          res_status_next = 1'b0;
          if (req_kind == KIND_DISPATCH) begin
            res_hid_next = mem_rdata.hid;
          end else if (!more_scan) begin
            count_next = count - CNT_W'(1);
          end
        end else if (more_scan) begin
          idx_next = idx_p1[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        // move the next slot down one place
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        mem_raddr = idx_p2[IDX_W-1:0];
        idx_next  = idx_p1[IDX_W-1:0];
        if (!more_shift) count_next = count - CNT_W'(1);
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Request and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_kind <= kind;
      req_pin  <= pin_mask;
      req_hid  <= handler_id;
    end
    idx        <= idx_next;
    res_status <= res_status_next;
    res_hid    <= res_hid_next;
  end

  // Ports
  assign count_wide      = {4'b0, count};
  assign in_stall        = (state != S_IDLE);
  assign out_valid       = (state == S_DONE);
  assign status          = res_status;
  assign matched_handler = res_hid;
  assign entry_count     = count_wide[3:0];

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= DEPTH_X)
    else $error("entry count beyond table depth");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_START))
    else $error("accepted request did not start");

  a_count_at_done: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (state == S_DONE))
    else $error("entry count changed outside result");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_START || state == S_SHIFT))
    else $error("table write outside append or shift");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (matched_handler == 8'd0))
    else $error("failed request carries a handler id");

endmodule

FILE: bench/dispatch_scoreboard_pkg.sv
`timescale 1ns / 1ps
package dispatch_scoreboard_pkg;

  import phdt_pkg::*;

  // Kind code that the block takes but does not act on
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  class dispatch_scoreboard;

    typedef struct {
      logic       status;
      logic [7:0] handler;
      logic [3:0] count;
    } outcome_t;

    // Shadow copy of the pin/handler table
    logic [15:0] pin_slot[TABLE_DEPTH];
    logic [7:0]  hid_slot[TABLE_DEPTH];
    int          used;

    outcome_t    expected_q[$];
    int          mismatches;
    int          checked;

    function new();
      used       = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Apply one accepted request to the shadow table and queue its outcome
    function void note_request(logic [1:0] kind, logic [15:0] pin, logic [7:0] hid);
      outcome_t res;
      int       hit;
      res.status  = 1'b1;
      res.handler = 8'd0;
      hit = -1;
      case (kind)
        KIND_REGISTER: begin
          if (used < TABLE_DEPTH) begin
            pin_slot[used] = pin;
            hid_slot[used] = hid;
            used++;
            res.status = 1'b0;
          end
        end
        KIND_UNREGISTER: begin
          for (int i = 0; i < used; i++)
            if (hit < 0 && pin_slot[i] == pin && hid_slot[i] == hid) hit = i;
          if (hit >= 0) begin
            // close the gap left by the removed pair
            for (int j = hit; j + 1 < used; j++) begin
              pin_slot[j] = pin_slot[j + 1];
              hid_slot[j] = hid_slot[j + 1];
            end
            used--;
            res.status = 1'b0;
          end
        end
        KIND_DISPATCH: begin
          for (int i = 0; i < used; i++)
            if (hit < 0 && pin_slot[i] == pin) hit = i;
          if (hit >= 0) begin
            res.status  = 1'b0;
            res.handler = hid_slot[hit];
          end
        end
        default: ;
      endcase
      res.count = used[3:0];
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one delivered result with the oldest outstanding outcome
    task check_result(logic st, logic [7:0] handler, logic [3:0] count);
      outcome_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0b handler=%0h count=%0d",
                                  st, handler, count));
      end else begin
        exp = expected_q.pop_front();
        if (st !== exp.status)
          report_mismatch($sformatf("status got %0b want %0b", st, exp.status));
        if (handler !== exp.handler)
          report_mismatch($sformatf("matched_handler got %0h want %0h", handler, exp.handler));
        if (count !== exp.count)
          report_mismatch($sformatf("entry_count got %0d want %0d", count, exp.count));
      end
    endtask

  endclass

endpackage

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;

  import phdt_pkg::*;
  import dispatch_scoreboard_pkg::*;

  localparam int RANDOM_REQUESTS = 1250;
  localparam int MAX_STALL_RUN   = 12;

  // Receiver stall modes
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_REGISTER;
  logic [15:0] pin_mask = 16'd0;
  logic [7:0]  handler_id = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [7:0]  matched_handler;
  logic [3:0]  entry_count;

  dispatch_scoreboard sb = new();
  int sent_by_kind[4];

  pin_handler_dispatch_table u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .pin_mask       (pin_mask),
    .handler_id     (handler_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .matched_handler(matched_handler),
    .entry_count    (entry_count)
  );

  always #6 clk = ~clk;

  // Drive one request and hold it until the block takes it
  task send_request(logic [1:0] k, logic [15:0] pin, logic [7:0] hid);
    @(negedge clk);
    in_valid   = 1'b1;
    kind       = k;
    pin_mask   = pin;
    handler_id = hid;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, pin, hid);
    sent_by_kind[k]++;
  endtask

  // Drop valid for a number of cycles
  task pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Hold off until every outstanding result has come back
  task drain_results();
    pause_sender(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Check every result the receiver takes
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, matched_handler, entry_count);
  end

  // Receiver stall pattern: episodes of free, light and heavy back-pressure
  int rx_mode = RX_FREE;
  int rx_left = 0;
  int rx_run  = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_HEAVY, RX_FREE);
      rx_left = $urandom_range(200, 20);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:  out_stall = 1'b0;
      RX_LIGHT: out_stall = ($urandom_range(3) == 0);
      default:  out_stall = ($urandom_range(3) != 0);
    endcase
    if (out_stall) rx_run++;
    else rx_run = 0;
    if (rx_run > MAX_STALL_RUN) begin
      out_stall = 1'b0;
      rx_run    = 0;
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [15:0] pin_pool[6];
    logic [1:0]  k;
    logic [15:0] pin;
    logic [7:0]  hid;
    int          burst;
    int          roll;
    int          idx;
    int          sent;

    pin_pool = '{16'h0001, 16'h0002, 16'h0080, 16'h8000, 16'hFFFF, 16'h0000};

    // hold reset, release at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, fill to full, lookups, removals
    send_request(KIND_DISPATCH,   16'h1234, 8'h00);
    send_request(KIND_UNREGISTER, 16'h1234, 8'h05);
    send_request(KIND_UNUSED,     16'hFFFF, 8'hFF);
    send_request(KIND_REGISTER,   16'h0000, 8'h00);
    send_request(KIND_REGISTER,   16'hFFFF, 8'hFF);
    send_request(KIND_REGISTER,   16'h0001, 8'h10);
    send_request(KIND_REGISTER,   16'h0001, 8'h20);
    send_request(KIND_REGISTER,   16'h8000, 8'h80);
    send_request(KIND_REGISTER,   16'h0001, 8'h10);
    send_request(KIND_REGISTER,   16'h00FF, 8'h7F);
    send_request(KIND_REGISTER,   16'hAAAA, 8'h55);
    send_request(KIND_REGISTER,   16'h5555, 8'hAA);
    send_request(KIND_DISPATCH,   16'h0001, 8'hEE);
    send_request(KIND_DISPATCH,   16'hFFFF, 8'h00);
    send_request(KIND_DISPATCH,   16'h0000, 8'h00);
    send_request(KIND_DISPATCH,   16'h1235, 8'h00);
    send_request(KIND_UNREGISTER, 16'h0001, 8'h30);
    send_request(KIND_UNREGISTER, 16'h0001, 8'h10);
    send_request(KIND_DISPATCH,   16'h0001, 8'h00);
    send_request(KIND_UNUSED,     16'h0000, 8'h00);
    send_request(KIND_UNREGISTER, 16'hAAAA, 8'h55);
    send_request(KIND_UNREGISTER, 16'h0000, 8'h00);
    drain_results();

    // random: bursts of requests over a small pin pool, with some noise
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(20, 1);
      repeat (burst) begin
        roll = $urandom_range(99);
        // steer toward removals when the table fills up, and back again
        if (roll < 5)
          k = KIND_UNUSED;
        else if (roll < 40)
          k = (sb.used >= TABLE_DEPTH - 1 && $urandom_range(1)) ? KIND_UNREGISTER
                                                              : KIND_REGISTER;
        else if (roll < 70)
          k = (sb.used <= 1 && $urandom_range(1)) ? KIND_REGISTER : KIND_UNREGISTER;
        else
          k = KIND_DISPATCH;
        pin = pin_pool[$urandom_range(5)];
        hid = 8'($urandom_range(3));
        if ($urandom_range(3) == 0) begin
          pin = 16'($urandom);
          hid = 8'($urandom);
        end else if (k != KIND_REGISTER && sb.used > 0 && $urandom_range(3) != 0) begin
          // aim at a pair that is really in the table
          idx = $urandom_range(sb.used - 1);
          pin = sb.pin_slot[idx];
          hid = sb.hid_slot[idx];
        end
        send_request(k, pin, hid);
        sent++;
        if (sent % 300 == 0) drain_results();
      end
      if ($urandom_range(3) != 0) pause_sender($urandom_range(8, 1));
    end

    // let the last results come back
    drain_results();
    repeat (40) @(posedge clk);

    $display("Sent %0d register, %0d unregister, %0d dispatch, %0d unused-kind requests",
             sent_by_kind[KIND_REGISTER], sent_by_kind[KIND_UNREGISTER],
             sent_by_kind[KIND_DISPATCH], sent_by_kind[KIND_UNUSED]);
    $display("Checked %0d results, %0d field mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
